>>> rtl/sha1_pkg.sv
// Shared types, constants and helper functions for the SHA-1 hash engine.
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned RND_W = 7;

	localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t K_0 = 32'h5A827999;
	localparam word_t K_1 = 32'h6ED9EBA1;
	localparam word_t K_2 = 32'h8F1BBCDC;
	localparam word_t K_3 = 32'hCA62C1D6;

	// Commands from the sequencer to the message window.
	typedef struct packed {
		logic push;
		logic [7:0] byte_val;
		logic step;
	} sched_cmd_t;

	// Commands from the sequencer to the round unit.
	typedef struct packed {
		logic load;
		logic step;
	} round_cmd_t;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		word_t res;
		res = (x << n) | (x >> (6'd32 - {1'b0, n}));
		return res;
	endfunction

	function automatic word_t round_k(input logic [RND_W-1:0] rnd);
		word_t k;
		if (rnd < 7'd20) k = K_0;
		else if (rnd < 7'd40) k = K_1;
		else if (rnd < 7'd60) k = K_2;
		else k = K_3;
		return k;
	endfunction

	function automatic word_t round_f(input logic [RND_W-1:0] rnd, input word_t b,
		input word_t c, input word_t d);
		word_t f;
		if (rnd < 7'd20) f = (b & c) | (~b & d);
		else if (rnd < 7'd40) f = b ^ c ^ d;
		else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

>>> rtl/sha1_sched.sv
// Block buffer and 16-word message schedule window in one shift line.
module sha1_sched (
	input  logic                clk,
	input  sha1_pkg::sched_cmd_t cmd,
	output sha1_pkg::word_t     w_cur
);

	logic [15:0][31:0] win_q;
	sha1_pkg::word_t   w_new;

	assign w_cur = win_q[0];
	assign w_new = sha1_pkg::rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 5'd1);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			// Shift one byte in at the tail; the first byte ends up in the top of word 0.
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], cmd.byte_val};
		end else if (cmd.step) begin
			win_q <= {w_new, win_q[15:1]};
		end
	end

endmodule

>>> rtl/sha1_round.sv
// Shared SHA-1 round unit: working variables a..e and the round counter.
module sha1_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::round_cmd_t cmd,
	input  sha1_pkg::chain_t     chain,
	input  sha1_pkg::word_t      w_cur,
	output sha1_pkg::chain_t     work,
	output logic                 rnd_last
);

	sha1_pkg::chain_t             work_q;
	logic [sha1_pkg::RND_W-1:0]   rnd_q;
	sha1_pkg::word_t              t_sum;

	assign work = work_q;
	assign rnd_last = (rnd_q == 7'(sha1_pkg::ROUNDS - 1));

	assign t_sum = sha1_pkg::rotl(work_q[0], 5'd5)
		+ sha1_pkg::round_f(rnd_q, work_q[1], work_q[2], work_q[3])
		+ work_q[4] + sha1_pkg::round_k(rnd_q) + w_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cmd.load) begin
			rnd_q <= '0;
		end else if (cmd.step) begin
			rnd_q <= rnd_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= chain;
		end else if (cmd.step) begin
			work_q[0] <= t_sum;
			work_q[1] <= work_q[0];
			work_q[2] <= sha1_pkg::rotl(work_q[1], 5'd30);
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3];
		end
	end

endmodule

>>> rtl/sha1_hash_engine.sv
// SHA-1 hash engine: takes one message byte per beat and returns the five-word digest.
// Message bytes are taken one per cycle while the engine is idle. Each 64th byte
// starts a compression that holds off input: 80 rounds on one shared round unit,
// one round per cycle, and a final step to fold the result into the chaining words.
// A beat with message_end set starts padding: the 0x80 byte, zero bytes and the
// eight length bytes go through the same byte path at one per cycle, pausing for
// each of the one or two more compressions, after which the digest leaves as five
// beats, H0 first, word_last on the fifth. Input stays stalled until the last digest
// beat is taken; the engine then starts the next message fresh.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        word_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [1:0] PH_ONE  = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;

	localparam logic [2:0] LAST_IDX = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          ret_q;
	logic [1:0]          phase_q;
	logic [2:0]          len_idx_q;
	logic [60:0]         len_q;
	logic [60:0]         cnt_q;
	logic [2:0]          out_idx_q;
	sha1_pkg::chain_t    chain_q;

	logic                push;
	logic [7:0]          push_byte;
	logic [5:0]          pos;
	logic                blk_full;
	logic [63:0]         len_bits;
	logic [7:0]          len_byte;
	sha1_pkg::sched_cmd_t sched_cmd;
	sha1_pkg::round_cmd_t round_cmd;
	sha1_pkg::word_t     w_cur;
	sha1_pkg::chain_t    work;
	logic                rnd_last;

	assign pos = cnt_q[5:0];
	assign len_bits = {len_q, 3'b000};
	assign len_byte = 8'(len_bits >> {~len_idx_q, 3'b000});

	always_comb begin
		push = 1'b0;
		push_byte = data_byte;
		case (state_q)
			ST_IDLE: push = in_valid && byte_present;
			ST_PAD: begin
				push = 1'b1;
				case (phase_q)
					PH_ONE:  push_byte = 8'h80;
					PH_ZERO: push_byte = 8'h00;
					PH_LEN:  push_byte = len_byte;
					default: push_byte = 8'h00;
				endcase
			end
			default: push = 1'b0;
		endcase
	end

	assign blk_full = push && (pos == 6'd63);

	assign sched_cmd.push = push;
	assign sched_cmd.byte_val = push_byte;
	assign sched_cmd.step = (state_q == ST_COMP);
	assign round_cmd.load = blk_full;
	assign round_cmd.step = (state_q == ST_COMP);

	sha1_sched u_sched (
		.clk   (clk),
		.cmd   (sched_cmd),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (round_cmd),
		.chain    (chain_q),
		.w_cur    (w_cur),
		.work     (work),
		.rnd_last (rnd_last)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign digest_word = chain_q[out_idx_q];
	assign word_last = (out_idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			phase_q <= PH_ONE;
			len_idx_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			out_idx_q <= '0;
			chain_q <= sha1_pkg::H_INIT;
		end else begin
			if (push) begin
				cnt_q <= cnt_q + 61'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (message_end) begin
							len_q <= byte_present ? cnt_q + 61'd1 : cnt_q;
							phase_q <= PH_ONE;
							len_idx_q <= '0;
						end
						if (blk_full) begin
							state_q <= ST_COMP;
							ret_q <= message_end ? ST_PAD : ST_IDLE;
						end else if (message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (phase_q == PH_LEN) begin
						len_idx_q <= len_idx_q + 3'd1;
					end else begin
						// Length field starts once the fill reaches byte 56.
						phase_q <= (pos == 6'd55) ? PH_LEN : PH_ZERO;
					end
					if (blk_full) begin
						state_q <= ST_COMP;
						ret_q <= (phase_q == PH_LEN && len_idx_q == 3'd7) ? ST_OUT : ST_PAD;
					end
				end
				ST_COMP: begin
					if (rnd_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (out_idx_q == LAST_IDX) begin
							// Last beat gone: start the next message fresh.
							out_idx_q <= '0;
							state_q <= ST_IDLE;
							chain_q <= sha1_pkg::H_INIT;
							cnt_q <= '0;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The digest only leaves once padding has closed a whole block.
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> cnt_q[5:0] == 6'd0)
		else $error("digest output with a partial block");

	// A compression starts only right after the 64th byte of a block.
	a_comp_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_COMP) |-> cnt_q[5:0] == 6'd0)
		else $error("compression started on a partial block");

	// Length bytes always land in the last eight bytes of the block.
	a_len_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD && phase_q == PH_LEN |-> cnt_q[5:3] == 3'd7)
		else $error("length byte outside its slot");

	// After the final digest beat the engine is idle with a fresh chain.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && word_last |=>
			state_q == ST_IDLE && chain_q == sha1_pkg::H_INIT && cnt_q == '0)
		else $error("engine did not restart after the digest");

endmodule
